/* sv/spur_pkg.sv */
// ----------------------------------------------------------------------------
// spur_pkg: shared types and constants of the single-pin ultrasonic ranger
// Phase codes, register indexes, counter sizing and the centimeter divider.
// ----------------------------------------------------------------------------
package spur_pkg;

    // tick counter width; 16 to 32
    localparam int COUNT_WIDTH = 24;

    localparam int ECHO_W = 24;
    localparam int DIST_W = 19;
    localparam int LOW_W  = 8;
    localparam int HIGH_W = 8;
    localparam int TMO_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [LOW_W-1:0]  RST_TRIG_LOW  = LOW_W'(2);
    localparam logic [HIGH_W-1:0] RST_TRIG_HIGH = HIGH_W'(5);
    localparam logic [TMO_W-1:0]  RST_TIMEOUT   = TMO_W'(1000000);

    localparam logic [ECHO_W-1:0] ECHO_MAX = {ECHO_W{1'b1}};

    // (w + 29) / 58 as a multiply by ceil(2^31 / 58) and a shift; exact for
    // every sum below 2^25
    localparam int DIST_SHIFT = 31;
    localparam int DIST_ROUND = 29;
    localparam int SUM_W      = ECHO_W + 1;
    localparam int RECIP_W    = 26;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIST_RECIP = RECIP_W'(37025581);

    typedef enum logic [5:0] {
        PH_IDLE_DRV  = 6'b000001,
        PH_IDLE_REL  = 6'b000010,
        PH_TRIG_LOW  = 6'b000100,
        PH_TRIG_HIGH = 6'b001000,
        PH_WAIT_RISE = 6'b010000,
        PH_MEASURE   = 6'b100000
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIG_LOW  = 2'd0,
        CFG_TRIG_HIGH = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } t_kind;

    typedef enum logic {
        ST_OK      = 1'b0,
        ST_TIMEOUT = 1'b1
    } t_status;

    // result fields that leave the state-update stage
    typedef struct packed {
        logic              drive_en;
        logic              drive_lvl;
        logic              busy;
        logic              done;
        logic              status;
        logic [ECHO_W-1:0] echo;
    } t_mid;

    function automatic logic [DIST_W-1:0] f_distance(input logic [ECHO_W-1:0] w);
        logic [SUM_W-1:0]  sum;
        logic [PROD_W-1:0] prod;
        sum  = SUM_W'(w) + SUM_W'(DIST_ROUND);
        prod = PROD_W'(sum) * PROD_W'(DIST_RECIP);
        return prod[DIST_SHIFT +: DIST_W];
    endfunction

endpackage

/* sv/single_pin_ultrasonic_ranger.sv */
// ----------------------------------------------------------------------------
// single_pin_ultrasonic_ranger: trigger and echo timing on one sensor pin
// Three-stage pipeline: input register, phase/counter update, distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): one request per microsecond tick
//   (i_kind = tick, with the sampled pin level) or a start request. A start
//   while a measurement runs is dropped without counting as a tick.
//   Result channel (o_res_valid / i_res_ready): exactly one result per input
//   request, in order: pin drive enable and level, busy, a done pulse, and
//   the status, echo width and distance of the last finished measurement.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): register index
//   and data; write only while the block is idle and drained.
//   A result passes the input, middle and output registers. Throughput:
//   one request per cycle while results are taken; the only multiply sits in
//   the last stage (centimeter conversion), the phase logic in the middle one.
//   Reset clears the pipeline, restores the register defaults and puts the
//   block in idle with the pin driven low. When the receiver stalls, the
//   output register holds and earlier stages keep filling until all three
//   are full; only then does o_in_ready drop.
// ----------------------------------------------------------------------------
module single_pin_ultrasonic_ranger
    import spur_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic                  i_pin_level,

    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic                  o_pin_drive_enable,
    output logic                  o_pin_drive_level,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic                  o_status,
    output logic [ECHO_W-1:0]     o_echo_time_ticks,
    output logic [DIST_W-1:0]     o_range_cm
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration
    logic [LOW_W-1:0]  r_trig_low;
    logic [HIGH_W-1:0] r_trig_high;
    logic [TMO_W-1:0]  r_timeout;

    // pipeline control
    logic r_in_vld, r_mid_vld, r_out_vld;
    logic w_out_adv, w_mid_adv, w_in_adv;

    // input register
    logic r_in_kind, r_in_lvl;

    // ranging state
    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [ECHO_W-1:0]      r_echo, n_echo;
    logic                   r_status, n_status;
    logic                   w_done;

    logic [COUNT_WIDTH-1:0] w_inc;
    logic [31:0]            w_inc32;
    logic                   w_tmo;
    logic [ECHO_W-1:0]      w_echo_sat;

    t_mid r_mid, n_mid;

    logic [ECHO_W-1:0] r_out_echo;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_en, r_out_lvl, r_out_busy, r_out_done, r_out_st;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_low  <= RST_TRIG_LOW;
            r_trig_high <= RST_TRIG_HIGH;
            r_timeout   <= RST_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TRIG_LOW:  r_trig_low  <= i_cfg_data[LOW_W-1:0];
                CFG_TRIG_HIGH: r_trig_high <= i_cfg_data[HIGH_W-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // each stage moves when the next one is empty or moving
    assign w_out_adv  = !r_out_vld || i_res_ready;
    assign w_mid_adv  = !r_mid_vld || w_out_adv;
    assign w_in_adv   = !r_in_vld  || w_mid_adv;
    assign o_in_ready = w_in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_adv)  r_in_vld  <= i_in_valid;
            if (w_mid_adv) r_mid_vld <= r_in_vld;
            if (w_out_adv) r_out_vld <= r_mid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_in_valid) begin
            r_in_kind <= i_kind;
            r_in_lvl  <= i_pin_level;
        end
    end

    // saturating count and timeout check on the advanced count
    always_comb begin
        w_inc      = (r_tick == CNT_MAX) ? r_tick : r_tick + COUNT_WIDTH'(1);
        w_inc32    = 32'(w_inc);
        w_tmo      = (w_inc32 > 32'(r_timeout)) || (w_inc == CNT_MAX);
        w_echo_sat = (w_inc32 > 32'(ECHO_MAX)) ? ECHO_MAX : w_inc32[ECHO_W-1:0];
    end

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_echo   = r_echo;
        n_status = r_status;
        w_done   = 1'b0;
        if (r_in_kind == KIND_START) begin
            if (r_phase == PH_IDLE_DRV || r_phase == PH_IDLE_REL) begin
                n_tick  = '0;
                n_phase = (r_trig_low == '0) ? PH_TRIG_HIGH : PH_TRIG_LOW;
            end
        end else begin
            unique case (r_phase)
                PH_TRIG_LOW: begin
                    n_tick = w_inc;
                    if (w_inc32 >= 32'(r_trig_low)) begin
                        n_tick  = '0;
                        n_phase = PH_TRIG_HIGH;
                    end
                end
                PH_TRIG_HIGH: begin
                    n_tick = w_inc;
                    if (w_inc32 >= 32'(r_trig_high)) begin
                        n_tick  = '0;
                        n_phase = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE: begin
                    if (r_in_lvl) begin
                        n_tick  = '0;
                        n_phase = PH_MEASURE;
                    end else begin
                        n_tick = w_inc;
                        if (w_tmo) begin
                            n_status = ST_TIMEOUT;
                            n_echo   = '0;
                            w_done   = 1'b1;
                            n_phase  = PH_IDLE_REL;
                        end
                    end
                end
                PH_MEASURE: begin
                    n_tick = w_inc;
                    if (!r_in_lvl) begin
                        n_echo   = w_echo_sat;
                        n_status = ST_OK;
                        w_done   = 1'b1;
                        n_phase  = PH_IDLE_DRV;
                    end else if (w_tmo) begin
                        n_status = ST_TIMEOUT;
                        n_echo   = '0;
                        w_done   = 1'b1;
                        n_phase  = PH_IDLE_REL;
                    end
                end
                PH_IDLE_DRV, PH_IDLE_REL: ;
                default: ;
            endcase
        end

        n_mid.drive_en  = (n_phase == PH_IDLE_DRV) || (n_phase == PH_TRIG_LOW)
                          || (n_phase == PH_TRIG_HIGH);
        n_mid.drive_lvl = (n_phase == PH_TRIG_HIGH);
        n_mid.busy      = !((n_phase == PH_IDLE_DRV) || (n_phase == PH_IDLE_REL));
        n_mid.done      = w_done;
        n_mid.status    = n_status;
        n_mid.echo      = n_echo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE_DRV;
            r_tick   <= '0;
            r_echo   <= '0;
            r_status <= ST_OK;
        end else if (r_in_vld && w_mid_adv) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_echo   <= n_echo;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld && w_mid_adv) begin
            r_mid <= n_mid;
        end
    end

    // centimeter conversion in the output stage
    always_ff @(posedge i_clk) begin
        if (r_mid_vld && w_out_adv) begin
            r_out_en   <= r_mid.drive_en;
            r_out_lvl  <= r_mid.drive_lvl;
            r_out_busy <= r_mid.busy;
            r_out_done <= r_mid.done;
            r_out_st   <= r_mid.status;
            r_out_echo <= r_mid.echo;
            r_out_dist <= f_distance(r_mid.echo);
        end
    end

    assign o_res_valid        = r_out_vld;
    assign o_pin_drive_enable = r_out_en;
    assign o_pin_drive_level  = r_out_lvl;
    assign o_busy_res         = r_out_busy;
    assign o_done_res         = r_out_done;
    assign o_status           = r_out_st;
    assign o_echo_time_ticks  = r_out_echo;
    assign o_range_cm         = r_out_dist;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_done_res) |-> !o_busy_res)
        else $error("finished measurement reported as busy");

    a_level_needs_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_pin_drive_level) |-> o_pin_drive_enable)
        else $error("high level driven on a released pin");

    a_timeout_zero_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status) |-> (o_echo_time_ticks == '0 && o_range_cm == '0))
        else $error("timeout result carries an echo width");

    a_mid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_vld && !w_mid_adv) |=> (r_mid_vld && $stable(r_mid)))
        else $error("stalled middle stage lost its request");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: single_pin_ultrasonic_ranger
// Runs trigger, echo-wait and echo-measure sequences under several register
// settings, tracks the expected pin, busy, done and reading outputs of every
// request and compares each result field in order, with random idling on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench
    import spur_pkg::*;
();

    localparam int     HALF_PERIOD   = 4;
    localparam int     RESET_CYCLES  = 7;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     STALL_LIMIT   = 5000;
    localparam int     RANDOM_ITEMS  = 200;
    localparam int     QUIET_ITEMS   = 60;
    localparam int     ECHO_PER_CM   = 58;
    localparam longint CNT_MAX       = (longint'(1) << COUNT_WIDTH) - 1;

    typedef struct packed {
        logic              drive_en;
        logic              drive_lvl;
        logic              busy;
        logic              done;
        logic              status;
        logic [ECHO_W-1:0] echo;
        logic [DIST_W-1:0] cm;
    } t_reading;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind      = 1'b0;
    logic                  i_pin_level = 1'b0;
    logic                  o_res_valid;
    logic                  i_res_ready = 1'b0;
    logic                  o_pin_drive_enable;
    logic                  o_pin_drive_level;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_status;
    logic [ECHO_W-1:0]     o_echo_time_ticks;
    logic [DIST_W-1:0]     o_range_cm;

    single_pin_ultrasonic_ranger dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_pin_level        (i_pin_level),
        .o_res_valid        (o_res_valid),
        .i_res_ready        (i_res_ready),
        .o_pin_drive_enable (o_pin_drive_enable),
        .o_pin_drive_level  (o_pin_drive_level),
        .o_busy_res         (o_busy_res),
        .o_done_res         (o_done_res),
        .o_status           (o_status),
        .o_echo_time_ticks  (o_echo_time_ticks),
        .o_range_cm         (o_range_cm)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // tracked ranger state and registers
    t_phase            trk_phase      = PH_IDLE_DRV;
    logic [COUNT_WIDTH-1:0] trk_ticks = '0;
    logic [ECHO_W-1:0] trk_echo       = '0;
    t_status           trk_status     = ST_OK;
    logic [LOW_W-1:0]  trk_trig_low   = RST_TRIG_LOW;
    logic [HIGH_W-1:0] trk_trig_high  = RST_TRIG_HIGH;
    logic [TMO_W-1:0]  trk_timeout    = RST_TIMEOUT;

    t_reading expected_readings[$];

    int n_sent      = 0;
    int n_errors    = 0;
    int src_gap_pct = 20;
    int idle_cycles = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    function automatic logic ranger_busy();
        return trk_phase inside {PH_TRIG_LOW, PH_TRIG_HIGH, PH_WAIT_RISE, PH_MEASURE};
    endfunction

    function automatic logic echo_overdue();
        return longint'(trk_ticks) > longint'(trk_timeout) || longint'(trk_ticks) >= CNT_MAX;
    endfunction

    task automatic bump_ticks();
        if (longint'(trk_ticks) < CNT_MAX)
            trk_ticks++;
    endtask

    task automatic end_with_timeout();
        trk_status = ST_TIMEOUT;
        trk_echo   = '0;
        trk_phase  = PH_IDLE_REL;
    endtask

    // advance the tracked state by one request and queue the reading it gives
    task automatic ranger_step(input t_kind k, input logic lvl);
        t_reading r;
        logic     done;
        done = 1'b0;
        if (k == KIND_START) begin
            if (trk_phase == PH_IDLE_DRV || trk_phase == PH_IDLE_REL) begin
                trk_ticks = '0;
                trk_phase = (trk_trig_low == '0) ? PH_TRIG_HIGH : PH_TRIG_LOW;
            end
        end else begin
            case (trk_phase)
                PH_TRIG_LOW: begin
                    bump_ticks();
                    if (trk_ticks >= trk_trig_low) begin
                        trk_ticks = '0;
                        trk_phase = PH_TRIG_HIGH;
                    end
                end
                PH_TRIG_HIGH: begin
                    bump_ticks();
                    if (trk_ticks >= trk_trig_high) begin
                        trk_ticks = '0;
                        trk_phase = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE: begin
                    if (lvl) begin
                        trk_ticks = '0;
                        trk_phase = PH_MEASURE;
                    end else begin
                        bump_ticks();
                        if (echo_overdue()) begin
                            end_with_timeout();
                            done = 1'b1;
                        end
                    end
                end
                PH_MEASURE: begin
                    bump_ticks();
                    if (!lvl) begin
                        trk_echo   = (longint'(trk_ticks) > longint'(ECHO_MAX)) ?
                                     ECHO_MAX : ECHO_W'(trk_ticks);
                        trk_status = ST_OK;
                        trk_phase  = PH_IDLE_DRV;
                        done       = 1'b1;
                    end else if (echo_overdue()) begin
                        end_with_timeout();
                        done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.drive_en  = trk_phase inside {PH_IDLE_DRV, PH_TRIG_LOW, PH_TRIG_HIGH};
        r.drive_lvl = (trk_phase == PH_TRIG_HIGH);
        r.busy      = ranger_busy();
        r.done      = done;
        r.status    = trk_status;
        r.echo      = trk_echo;
        r.cm        = DIST_W'((longint'(trk_echo) + DIST_ROUND) / ECHO_PER_CM);
        expected_readings.push_back(r);
    endtask

    task automatic send_req(input t_kind k, input logic lvl);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= k;
        i_pin_level <= lvl;
        do @(posedge i_clk); while (!o_in_ready);
        ranger_step(k, lvl);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // finish any running sequence with low samples, then let the pipeline empty
    task automatic quiesce();
        while (ranger_busy())
            send_req(KIND_TICK, 1'b0);
        drain();
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TRIG_LOW:  trk_trig_low  = val[LOW_W-1:0];
            CFG_TRIG_HIGH: trk_trig_high = val[HIGH_W-1:0];
            default:       trk_timeout   = val[TMO_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [LOW_W-1:0] lo, input logic [HIGH_W-1:0] hi,
                              input logic [TMO_W-1:0] tmo);
        quiesce();
        write_reg(CFG_TRIG_LOW, CFG_DATA_W'(lo));
        write_reg(CFG_TRIG_HIGH, CFG_DATA_W'(hi));
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    endtask

    task automatic maybe_restart(input int pct);
        if ($urandom_range(0, 99) < pct)
            send_req(KIND_START, 1'($urandom_range(0, 1)));
    endtask

    // one measurement: start, trigger ticks, wait_lo low samples, rising
    // sample, echo_hi high samples, falling sample; stop early on a timeout
    task automatic run_measure(input int wait_lo, input int echo_hi, input int restart_pct);
        int n;
        send_req(KIND_START, 1'($urandom_range(0, 1)));
        while (trk_phase == PH_TRIG_LOW || trk_phase == PH_TRIG_HIGH) begin
            maybe_restart(restart_pct);
            send_req(KIND_TICK, 1'($urandom_range(0, 1)));
        end
        n = 0;
        while (trk_phase == PH_WAIT_RISE && n < wait_lo) begin
            maybe_restart(restart_pct);
            send_req(KIND_TICK, 1'b0);
            n++;
        end
        if (trk_phase == PH_WAIT_RISE)
            send_req(KIND_TICK, 1'b1);
        n = 0;
        while (trk_phase == PH_MEASURE && n < echo_hi) begin
            maybe_restart(restart_pct);
            send_req(KIND_TICK, 1'b1);
            n++;
        end
        if (trk_phase == PH_MEASURE)
            send_req(KIND_TICK, 1'b0);
    endtask

    function automatic int pick_len(input int lim);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, lim + 2);
        return $urandom_range(0, (lim + 2 < 20) ? lim + 2 : 20);
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            n_errors++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_reading want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_readings.size() == 0) begin
                n_errors++;
                $display("%0t unexpected result: expected none, actual echo %0d",
                         $time, o_echo_time_ticks);
            end else begin
                want = expected_readings.pop_front();
                check_field("pin_drive_enable", want.drive_en, o_pin_drive_enable);
                check_field("pin_drive_level", want.drive_lvl, o_pin_drive_level);
                check_field("busy", want.busy, o_busy_res);
                check_field("done", want.done, o_done_res);
                check_field("status", want.status, o_status);
                check_field("echo_time_ticks", want.echo, o_echo_time_ticks);
                check_field("range_cm", want.cm, o_range_cm);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_res_valid && i_res_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: stall bursts whose density changes from epoch to epoch
    initial begin : result_side
        int stall_left;
        int stall_pct;
        int epoch;
        stall_left = 0;
        stall_pct  = 0;
        epoch      = 0;
        forever begin
            @(negedge i_clk);
            if (epoch == 0) begin
                epoch = 64;
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            epoch--;
            if (hold_req) begin
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_res_ready <= 1'b1;
            end else if (quiet) begin
                i_res_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_res_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                i_res_ready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // reset registers, idle ticks, a short echo and one at the rounding step
    task automatic test_reset_state();
        send_req(KIND_TICK, 1'b0);
        send_req(KIND_TICK, 1'b1);
        run_measure(3, 2, 0);
        run_measure(0, 28, 30);
    endtask

    // no low phase, zero high time treated as one tick, both timeouts,
    // and a start from the released idle state
    task automatic test_zero_trigger();
        set_config('0, '0, TMO_W'(4));
        run_measure(1, 2, 0);
        run_measure(9, 0, 0);
        run_measure(0, 9, 0);
        run_measure(0, 1, 0);
    endtask

    task automatic test_zero_timeout();
        set_config(LOW_W'(1), HIGH_W'(1), '0);
        run_measure(0, 0, 0);
        run_measure(1, 0, 0);
        run_measure(0, 1, 0);
    endtask

    task automatic test_extreme_config();
        set_config('1, '1, TMO_W'(16777214));
        run_measure(2, 3, 10);
    endtask

    // hold the result side while requests keep coming, so the input stalls
    task automatic test_backpressure();
        set_config(LOW_W'(2), HIGH_W'(3), TMO_W'(20));
        src_gap_pct = 0;
        hold_req    = 1'b1;
        repeat (3) run_measure(2, 5, 20);
        src_gap_pct = 20;
    endtask

    task automatic test_random_mix();
        int               start_n;
        int               tmo;
        logic [LOW_W-1:0] lo;
        logic [HIGH_W-1:0] hi;
        start_n = n_sent;
        while (n_sent - start_n < RANDOM_ITEMS) begin
            lo = ($urandom_range(0, 4) == 0) ? '0 : LOW_W'($urandom_range(1, 8));
            hi = ($urandom_range(0, 4) == 0) ? '0 : HIGH_W'($urandom_range(1, 8));
            case ($urandom_range(0, 9))
                0:       tmo = 0;
                1, 2:    tmo = $urandom_range(60, 200);
                default: tmo = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 2))
                0:       src_gap_pct = 0;
                1:       src_gap_pct = 10;
                default: src_gap_pct = 35;
            endcase
            quiet = (n_sent - start_n) >= RANDOM_ITEMS - QUIET_ITEMS;
            set_config(lo, hi, TMO_W'(tmo));
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 12))
                        send_req(($urandom_range(0, 3) == 0) ? KIND_START : KIND_TICK,
                                 1'($urandom_range(0, 1)));
                end else begin
                    run_measure(pick_len(tmo), pick_len(tmo), 10);
                end
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_zero_trigger();
        test_zero_timeout();
        test_extreme_config();
        test_backpressure();
        test_random_mix();
        drain();
        if (n_errors == 0 && expected_readings.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
